// ===== rtl/four_level_page_table_mapper_unit_macros.svh =====
// assertion macros for the page table mapper checker
// no dependencies; expects clk and rst_n in the scope of use
`ifndef FOUR_LEVEL_PAGE_TABLE_MAPPER_UNIT_MACROS_SVH
`define FOUR_LEVEL_PAGE_TABLE_MAPPER_UNIT_MACROS_SVH

// condition holds in the same cycle
`define FLPTM_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// condition holds in the following cycle
`define FLPTM_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/flptm_pkg.sv =====
// shared constants, codes and port structs of the page table mapper
// no dependencies
package flptm_pkg;

  localparam int NUM_TABLES  = 16;
  localparam int IDX_W       = 9;
  localparam int ENTRIES     = 1 << IDX_W;
  localparam int TBL_W       = (NUM_TABLES > 1) ? $clog2(NUM_TABLES) : 1;
  localparam int ADDR_W      = TBL_W + IDX_W;
  localparam int DEPTH       = NUM_TABLES * ENTRIES;
  localparam int CNT_W       = $clog2(NUM_TABLES + 1);
  localparam int VA_W        = 48;
  localparam int PA_W        = 52;
  localparam int PFN_W       = 40;
  localparam int FLAGS_W     = 12;
  localparam int USED_W      = 5;
  localparam int ENTRY_W     = 64;
  localparam int WORD_W      = ENTRY_W + 1;
  localparam int PRESENT_BIT = 0;
  localparam int PS_BIT      = 7;

  typedef enum logic [1:0] {
    ACT_MAP_4K    = 2'd0,
    ACT_MAP_2M    = 2'd1,
    ACT_UNMAP_4K  = 2'd2,
    ACT_TRANSLATE = 2'd3
  } action_t;

  typedef enum logic [1:0] {
    ST_DONE        = 2'd0,
    ST_NO_TABLE    = 2'd1,
    ST_NOT_PRESENT = 2'd2
  } status_t;

  // store word: bit 64 is the table epoch tag, bits 63:0 the entry
  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] addr;
    logic [WORD_W-1:0] data;
  } store_wr_t;

  typedef struct packed {
    logic              re;
    logic [ADDR_W-1:0] addr;
  } store_rd_t;

endpackage

// ===== rtl/flptm_store.sv =====
// page table store: one write port, one registered read port
// depends on flptm_pkg
module flptm_store (
  input  logic                        clk,
  input  flptm_pkg::store_wr_t        wr,
  input  flptm_pkg::store_rd_t        rd,
  output logic [flptm_pkg::WORD_W-1:0] rd_data
);

  logic [flptm_pkg::WORD_W-1:0] mem [flptm_pkg::DEPTH];

  always_ff @(posedge clk) begin
    if (wr.we) begin
      mem[wr.addr] <= wr.data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd.re) begin
      rd_data <= mem[rd.addr];
    end
  end

endmodule

// ===== rtl/flptm_pfn_alu.sv =====
// shared frame-number adder: pool offset of an entry, or address of a pool table
// depends on flptm_pkg
module flptm_pfn_alu (
  input  logic [flptm_pkg::PFN_W-1:0] a,
  input  logic [flptm_pkg::PFN_W-1:0] b,
  input  logic                        sub,
  output logic [flptm_pkg::PFN_W-1:0] sum,
  output logic                        in_pool,
  output logic [flptm_pkg::TBL_W-1:0] tbl
);

  logic [flptm_pkg::PFN_W-1:0] b_op;

  assign b_op    = sub ? ~b : b;
  assign sum     = a + b_op + flptm_pkg::PFN_W'(sub);
  // offset from the pool base must name one of the pool tables
  assign in_pool = (sum < flptm_pkg::PFN_W'(flptm_pkg::NUM_TABLES));
  assign tbl     = sum[flptm_pkg::TBL_W-1:0];

endmodule

// ===== rtl/four_level_page_table_mapper_unit.sv =====
// Four-level page table mapper. Keeps NUM_TABLES page tables of 512 entries in one
// store with one write and one registered read port (table 0 is the root) and serves
// one request at a time: map a 4K page, map a 2M page, unmap a 4K page or translate.
// After reset the store is swept clean, one entry a cycle over all NUM_TABLES*512
// entries; in_ready stays low meanwhile, while configuration writes are taken at any
// time. A request is then accepted in the idle state; each table read passes a read
// state and an evaluate state (registered read of the store), a map first passes a
// free-table check state and then writes each entry in the write state, and the
// result state ends the request. A new item is taken only after the previous one has
// gone to the result register, which holds its result until out_ready. Allocated
// tables read as zero through a per-table epoch tag, so allocation costs no clearing
// sweep.
// depends on flptm_pkg, flptm_store, flptm_pfn_alu
module four_level_page_table_mapper_unit (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_wr_en,
  input  logic [flptm_pkg::PA_W-1:0]    cfg_table_pool_base,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [1:0]                    in_action,
  input  logic [flptm_pkg::VA_W-1:0]    in_virtual_address,
  input  logic [flptm_pkg::PA_W-1:0]    in_physical_address,
  input  logic [flptm_pkg::FLAGS_W-1:0] in_entry_flags,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [1:0]                    out_status,
  output logic [flptm_pkg::PA_W-1:0]    out_frame_address,
  output logic [flptm_pkg::USED_W-1:0]  out_tables_used
);

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_RD,
    S_EVAL,
    S_CHK,
    S_WR,
    S_RESP
  } state_t;

  state_t                        state_r;
  logic [flptm_pkg::ADDR_W-1:0]  clr_addr_r;
  logic [flptm_pkg::PFN_W-1:0]   base_pfn_r;
  flptm_pkg::action_t            act_r;
  logic [flptm_pkg::VA_W-1:0]    va_r;
  logic [flptm_pkg::PA_W-1:0]    pa_r;
  logic [flptm_pkg::FLAGS_W-1:0] flags_r;
  logic [1:0]                    lvl_r;
  logic [1:0]                    missing_r;
  logic [flptm_pkg::TBL_W-1:0]   cur_r;
  logic [flptm_pkg::TBL_W-1:0]   rd_tbl_r;
  logic [flptm_pkg::CNT_W-1:0]   next_r;
  logic [flptm_pkg::NUM_TABLES-1:0] epoch_r;
  flptm_pkg::status_t            status_r;
  logic [flptm_pkg::PA_W-1:0]    frame_r;
  logic                          out_valid_r;
  flptm_pkg::status_t            out_status_r;
  logic [flptm_pkg::PA_W-1:0]    out_frame_r;
  logic [flptm_pkg::USED_W-1:0]  out_used_r;

  flptm_pkg::store_wr_t          wr;
  flptm_pkg::store_rd_t          rd;
  logic [flptm_pkg::WORD_W-1:0]  rd_data;
  logic [flptm_pkg::ENTRY_W-1:0] entry;
  logic [flptm_pkg::IDX_W-1:0]   lvl_idx;
  logic [flptm_pkg::IDX_W-1:0]   leaf_idx;
  logic [1:0]                    depth;
  logic                          is_map;
  logic                          unmap_hit;
  logic                          alloc;
  logic [flptm_pkg::PFN_W-1:0]   alu_a;
  logic [flptm_pkg::PFN_W-1:0]   alu_b;
  logic                          alu_sub;
  logic [flptm_pkg::PFN_W-1:0]   alu_sum;
  logic                          alu_in_pool;
  logic [flptm_pkg::TBL_W-1:0]   alu_tbl;
  logic [flptm_pkg::CNT_W:0]     need;

  flptm_store u_store (
    .clk     (clk),
    .wr      (wr),
    .rd      (rd),
    .rd_data (rd_data)
  );

  flptm_pfn_alu u_alu (
    .a       (alu_a),
    .b       (alu_b),
    .sub     (alu_sub),
    .sum     (alu_sum),
    .in_pool (alu_in_pool),
    .tbl     (alu_tbl)
  );

  always_comb begin
    unique case (lvl_r)
      2'd0:    lvl_idx = va_r[47:39];
      2'd1:    lvl_idx = va_r[38:30];
      2'd2:    lvl_idx = va_r[29:21];
      default: lvl_idx = va_r[20:12];
    endcase
  end

  assign leaf_idx = (act_r == flptm_pkg::ACT_MAP_2M) ? va_r[29:21] : va_r[20:12];
  assign is_map   = (act_r == flptm_pkg::ACT_MAP_4K) || (act_r == flptm_pkg::ACT_MAP_2M);
  assign depth    = (act_r == flptm_pkg::ACT_MAP_4K) ? 2'd3 : 2'd2;

  // a word tagged with an older epoch of its table predates the allocation
  assign entry = (rd_data[flptm_pkg::ENTRY_W] == epoch_r[rd_tbl_r])
               ? rd_data[flptm_pkg::ENTRY_W-1:0] : '0;

  assign unmap_hit = (state_r == S_EVAL) && (lvl_r == 2'd3)
                   && (act_r == flptm_pkg::ACT_UNMAP_4K) && entry[flptm_pkg::PRESENT_BIT];
  assign alloc     = (state_r == S_WR) && (lvl_r < depth);

  // the adder either offsets a walked entry from the pool base or builds a new table address
  always_comb begin
    if (state_r == S_WR) begin
      alu_a   = base_pfn_r;
      alu_b   = flptm_pkg::PFN_W'(next_r);
      alu_sub = 1'b0;
    end else begin
      alu_a   = entry[51:12];
      alu_b   = base_pfn_r;
      alu_sub = 1'b1;
    end
  end

  assign need = (flptm_pkg::CNT_W+1)'(next_r) + (flptm_pkg::CNT_W+1)'(missing_r);

  always_comb begin
    rd.re   = (state_r == S_RD);
    rd.addr = {cur_r, lvl_idx};
    wr.we   = 1'b0;
    wr.addr = {cur_r, leaf_idx};
    wr.data = '0;
    priority if (state_r == S_CLEAR) begin
      wr.we   = 1'b1;
      wr.addr = clr_addr_r;
    end else if (unmap_hit) begin
      wr.we   = 1'b1;
      wr.addr = {cur_r, va_r[20:12]};
      wr.data = {epoch_r[cur_r], 64'd0};
    end else if (alloc) begin
      wr.we   = 1'b1;
      wr.addr = {cur_r, lvl_idx};
      wr.data = {epoch_r[cur_r], 12'd0, alu_sum, flags_r};
    end else if (state_r == S_WR) begin
      wr.we   = 1'b1;
      wr.addr = {cur_r, leaf_idx};
      wr.data = {epoch_r[cur_r], 12'd0, pa_r | flptm_pkg::PA_W'(flags_r)
                 | ((act_r == flptm_pkg::ACT_MAP_2M) ? flptm_pkg::PA_W'(1 << flptm_pkg::PS_BIT)
                                                     : '0)};
    end else begin
      wr.we   = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_addr_r  <= '0;
      base_pfn_r  <= '0;
      next_r      <= flptm_pkg::CNT_W'(1);
      epoch_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        base_pfn_r <= cfg_table_pool_base[51:12];
      end
      // the result state reloads the register itself
      if (out_valid_r && out_ready && (state_r != S_RESP)) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_CLEAR: begin
          clr_addr_r <= clr_addr_r + 1'b1;
          if (clr_addr_r == flptm_pkg::ADDR_W'(flptm_pkg::DEPTH - 1)) begin
            state_r <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (in_valid) begin
            act_r    <= flptm_pkg::action_t'(in_action);
            va_r     <= in_virtual_address;
            pa_r     <= in_physical_address;
            flags_r  <= in_entry_flags;
            lvl_r    <= 2'd0;
            cur_r    <= '0;
            status_r <= flptm_pkg::ST_DONE;
            frame_r  <= '0;
            state_r  <= S_RD;
          end
        end
        S_RD: begin
          rd_tbl_r <= cur_r;
          state_r  <= S_EVAL;
        end
        S_EVAL: begin
          if (is_map) begin
            if (!entry[flptm_pkg::PRESENT_BIT]) begin
              missing_r <= depth - lvl_r;
              state_r   <= S_CHK;
            end else if ((lvl_r == 2'd2) && entry[flptm_pkg::PS_BIT]) begin
              status_r <= flptm_pkg::ST_NOT_PRESENT;
              state_r  <= S_RESP;
            end else if (!alu_in_pool) begin
              status_r <= flptm_pkg::ST_NOT_PRESENT;
              state_r  <= S_RESP;
            end else begin
              cur_r <= alu_tbl;
              lvl_r <= lvl_r + 2'd1;
              if (lvl_r == depth - 2'd1) begin
                missing_r <= 2'd0;
                state_r   <= S_CHK;
              end else begin
                state_r <= S_RD;
              end
            end
          end else if (lvl_r != 2'd3) begin
            if (!entry[flptm_pkg::PRESENT_BIT]) begin
              status_r <= flptm_pkg::ST_NOT_PRESENT;
              state_r  <= S_RESP;
            end else if ((lvl_r == 2'd2) && entry[flptm_pkg::PS_BIT]) begin
              // large page ends the walk at level 2
              if (act_r == flptm_pkg::ACT_TRANSLATE) begin
                frame_r <= {entry[51:21], 21'd0};
              end else begin
                status_r <= flptm_pkg::ST_NOT_PRESENT;
              end
              state_r <= S_RESP;
            end else if (!alu_in_pool) begin
              status_r <= flptm_pkg::ST_NOT_PRESENT;
              state_r  <= S_RESP;
            end else begin
              cur_r   <= alu_tbl;
              lvl_r   <= lvl_r + 2'd1;
              state_r <= S_RD;
            end
          end else begin
            if (!entry[flptm_pkg::PRESENT_BIT]) begin
              status_r <= flptm_pkg::ST_NOT_PRESENT;
            end else if (act_r == flptm_pkg::ACT_TRANSLATE) begin
              frame_r <= {entry[51:12], 12'd0};
            end
            state_r <= S_RESP;
          end
        end
        S_CHK: begin
          if (need > (flptm_pkg::CNT_W+1)'(flptm_pkg::NUM_TABLES)) begin
            status_r <= flptm_pkg::ST_NO_TABLE;
            state_r  <= S_RESP;
          end else begin
            state_r <= S_WR;
          end
        end
        S_WR: begin
          if (alloc) begin
            epoch_r[next_r[flptm_pkg::TBL_W-1:0]] <= 1'b1;
            cur_r  <= next_r[flptm_pkg::TBL_W-1:0];
            next_r <= next_r + 1'b1;
            lvl_r  <= lvl_r + 2'd1;
          end else begin
            state_r <= S_RESP;
          end
        end
        S_RESP: begin
          if (!out_valid_r || out_ready) begin
            out_valid_r  <= 1'b1;
            out_status_r <= status_r;
            out_frame_r  <= frame_r;
            out_used_r   <= flptm_pkg::USED_W'(next_r);
            state_r      <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign in_ready          = (state_r == S_IDLE);
  assign out_valid         = out_valid_r;
  assign out_status        = out_status_r;
  assign out_frame_address = out_frame_r;
  assign out_tables_used   = out_used_r;

endmodule

// ===== rtl/flptm_checker.sv =====
// port-level checker for the page table mapper, bound to the top level
// depends on flptm_pkg and four_level_page_table_mapper_unit_macros.svh
`include "four_level_page_table_mapper_unit_macros.svh"

module flptm_checker (
  input logic                         clk,
  input logic                         rst_n,
  input logic                         in_valid,
  input logic                         in_ready,
  input logic                         out_valid,
  input logic                         out_ready,
  input logic [1:0]                   out_status,
  input logic [flptm_pkg::PA_W-1:0]   out_frame_address,
  input logic [flptm_pkg::USED_W-1:0] out_tables_used
);

  // a waiting result holds still
  `FLPTM_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_status) && $stable(out_frame_address) && $stable(out_tables_used), "result changed while stalled")

  // an accepted item makes the block busy, so in_ready falls after the accept
  `FLPTM_ASSERT_NEXT(a_busy_after_accept, in_valid && in_ready, !in_ready, "ready right after accept")

  // only a successful request carries a frame
  `FLPTM_ASSERT_NOW(a_frame_zero, out_valid && (out_status != flptm_pkg::ST_DONE), out_frame_address == '0, "frame on failed request")

  // the root is always counted and the pool never overflows
  `FLPTM_ASSERT_NOW(a_used_range, out_valid, (out_tables_used != '0) && (out_tables_used <= flptm_pkg::USED_W'(flptm_pkg::NUM_TABLES)), "tables used out of range")

endmodule

bind four_level_page_table_mapper_unit flptm_checker u_flptm_checker (.*);
